// File: rtl/jetcm_pkg.sv
// jetcm_pkg: widths, types, constants and register codes for the jet colour map
// shared by the stream interfaces and the top level; depends on nothing
package jetcm_pkg;

	// field widths
	localparam int SAMPLE_BITS  = 16;
	localparam int CHANNEL_BITS = 8;

	// full channel intensity
	localparam int CHAN_FULL_INT = (2 ** CHANNEL_BITS) - 1;

	// the quotient never exceeds 4*full, so two bits more than a channel
	localparam int QUOT_BITS  = CHANNEL_BITS + 2;
	// the divider resolves two quotient bits in each stage
	localparam int DIV_STAGES = (QUOT_BITS + 1) / 2;
	localparam int QW         = 2 * DIV_STAGES;
	// partial remainder holds 4*full*d and the divisor shifted by the top quotient bit
	localparam int REM_BITS   = SAMPLE_BITS + QW;

	typedef logic [SAMPLE_BITS-1:0]  sample_t;
	typedef logic [CHANNEL_BITS-1:0] chan_t;
	typedef logic [REM_BITS-1:0]     rem_t;
	typedef logic [QW-1:0]           quot_t;

	localparam chan_t   CHAN_FULL   = chan_t'(CHAN_FULL_INT);
	localparam sample_t LOWER_RESET = '0;
	localparam sample_t UPPER_RESET = sample_t'(32'd65535);

	// multiplier constant 4*full
	localparam rem_t FULL4_MUL = rem_t'(4 * CHAN_FULL_INT);

	// quarter boundaries in quotient width
	localparam quot_t Q_F  = quot_t'(CHAN_FULL_INT);
	localparam quot_t Q_2F = quot_t'(2 * CHAN_FULL_INT);
	localparam quot_t Q_3F = quot_t'(3 * CHAN_FULL_INT);
	localparam quot_t Q_4F = quot_t'(4 * CHAN_FULL_INT);

	// configuration register indexes
	typedef enum logic [0:0] {
		REG_RANGE_LOWER = 1'b0,
		REG_RANGE_UPPER = 1'b1
	} cfg_reg_t;

endpackage

// File: rtl/jetcm_if.sv
// jetcm_if: valid/ready stream interfaces for sample words and pixel words
// depends on jetcm_pkg for field types
interface jetcm_sample_if;
	logic               valid;
	logic               ready;
	jetcm_pkg::sample_t sample;

	modport source (output valid, output sample, input ready);
	modport sink (input valid, input sample, output ready);
endinterface

interface jetcm_pixel_if;
	logic             valid;
	logic             ready;
	jetcm_pkg::chan_t red;
	jetcm_pkg::chan_t green;
	jetcm_pkg::chan_t blue;

	modport source (output valid, output red, output green, output blue, input ready);
	modport sink (input valid, input red, input green, input blue, output ready);
endinterface

// File: rtl/value_to_jet_colormap_top.sv
// value_to_jet_colormap_top: pipelined jet colour map, one sample word in, one pixel word out
// depends on jetcm_pkg and the stream interfaces in jetcm_if
//
//   channel   dir   handshake     payload
//   samples   in    valid/ready   sample
//   pixels    out   valid/ready   red, green, blue
//   cfg       in    cfg_wr_en     cfg_index, cfg_data
//
// one word per cycle while the pixel side is not stalling; the pipeline is made of the clamp stage,
// the constant multiply stage, the restoring divider
// (two quotient bits per stage) and the output register
// arst_n clears the valid bits and sets the range to its full span
// a stalled output holds every stage, empty ones too, so bubbles are never squeezed out
// and the input is refused until the pixel word is taken
module value_to_jet_colormap_top (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_wr_en,
	input  logic                    cfg_index,
	input  jetcm_pkg::sample_t      cfg_data,
	jetcm_sample_if.sink            samples,
	jetcm_pixel_if.source           pixels
);

	localparam int NS = jetcm_pkg::DIV_STAGES;

	// configuration registers
	jetcm_pkg::sample_t range_lower_q;
	jetcm_pkg::sample_t range_upper_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			range_lower_q <= jetcm_pkg::LOWER_RESET;
			range_upper_q <= jetcm_pkg::UPPER_RESET;
		end else if (cfg_wr_en) begin
			unique case (jetcm_pkg::cfg_reg_t'(cfg_index))
				jetcm_pkg::REG_RANGE_LOWER: range_lower_q <= cfg_data;
				jetcm_pkg::REG_RANGE_UPPER: range_upper_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// whole pipeline moves when the output register is free or being drained
	logic out_valid_q;
	logic advance;

	assign advance       = !out_valid_q || pixels.ready;
	assign samples.ready = advance;

	// stage 1: clamp and offsets
	logic               valid_s1;
	logic               empty_s1;
	jetcm_pkg::sample_t d_s1;
	jetcm_pkg::sample_t dv_s1;
	jetcm_pkg::sample_t clamped;

	always_comb begin
		clamped = samples.sample;
		if (samples.sample < range_lower_q) begin
			clamped = range_lower_q;
		end else if (samples.sample > range_upper_q) begin
			clamped = range_upper_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= samples.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			empty_s1 <= (range_upper_q <= range_lower_q);
			d_s1     <= clamped - range_lower_q;
			dv_s1    <= range_upper_q - range_lower_q;
		end
	end

	// stage 2: numerator 4*full*d
	logic               valid_s2;
	logic               empty_s2;
	jetcm_pkg::rem_t    num_s2;
	jetcm_pkg::sample_t dv_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			empty_s2 <= empty_s1;
			num_s2   <= jetcm_pkg::rem_t'(d_s1) * jetcm_pkg::FULL4_MUL;
			dv_s2    <= dv_s1;
		end
	end

	// restoring divider stages, two quotient bits each
	logic               div_valid_s [NS];
	logic               div_empty_s [NS];
	jetcm_pkg::rem_t    div_rem_s   [NS];
	jetcm_pkg::quot_t   div_quot_s  [NS];
	jetcm_pkg::sample_t div_dv_s    [NS];

	for (genvar k = 0; k < NS; k++) begin : g_div
		localparam int BHI = jetcm_pkg::QW - 1 - 2 * k;
		localparam int BLO = jetcm_pkg::QW - 2 - 2 * k;

		logic               valid_in;
		logic               empty_in;
		jetcm_pkg::rem_t    rem_in;
		jetcm_pkg::quot_t   quot_in;
		jetcm_pkg::sample_t dv_in;
		jetcm_pkg::rem_t    sub_hi;
		jetcm_pkg::rem_t    sub_lo;
		jetcm_pkg::rem_t    rem_mid;
		jetcm_pkg::rem_t    rem_out;
		jetcm_pkg::quot_t   quot_out;

		if (k == 0) begin : g_first
			assign valid_in = valid_s2;
			assign empty_in = empty_s2;
			assign rem_in   = num_s2;
			assign quot_in  = '0;
			assign dv_in    = dv_s2;
		end else begin : g_next
			assign valid_in = div_valid_s[k-1];
			assign empty_in = div_empty_s[k-1];
			assign rem_in   = div_rem_s[k-1];
			assign quot_in  = div_quot_s[k-1];
			assign dv_in    = div_dv_s[k-1];
		end

		assign sub_hi = jetcm_pkg::rem_t'(dv_in) << BHI;
		assign sub_lo = jetcm_pkg::rem_t'(dv_in) << BLO;

		// trial subtract for the upper then the lower bit
		always_comb begin
			quot_out = quot_in;
			rem_mid  = rem_in;
			if (rem_in >= sub_hi) begin
				rem_mid       = rem_in - sub_hi;
				quot_out[BHI] = 1'b1;
			end
			rem_out = rem_mid;
			if (rem_mid >= sub_lo) begin
				rem_out       = rem_mid - sub_lo;
				quot_out[BLO] = 1'b1;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				div_valid_s[k] <= 1'b0;
			end else if (advance) begin
				div_valid_s[k] <= valid_in;
			end
		end

		always_ff @(posedge clk) begin
			if (advance) begin
				div_empty_s[k] <= empty_in;
				div_rem_s[k]   <= rem_out;
				div_quot_s[k]  <= quot_out;
				div_dv_s[k]    <= dv_in;
			end
		end
	end

	// final stage: quarter select into the output register
	jetcm_pkg::quot_t xf;
	jetcm_pkg::quot_t xc;
	jetcm_pkg::chan_t red_d;
	jetcm_pkg::chan_t green_d;
	jetcm_pkg::chan_t blue_d;
	jetcm_pkg::chan_t red_q;
	jetcm_pkg::chan_t green_q;
	jetcm_pkg::chan_t blue_q;

	assign xf = div_quot_s[NS-1];
	assign xc = xf + jetcm_pkg::quot_t'(div_rem_s[NS-1] != '0);

	always_comb begin
		priority if (div_empty_s[NS-1]) begin
			red_d   = jetcm_pkg::CHAN_FULL;
			green_d = '0;
			blue_d  = '0;
		end else if (xf < jetcm_pkg::Q_F) begin
			red_d   = '0;
			green_d = jetcm_pkg::chan_t'(xf);
			blue_d  = jetcm_pkg::CHAN_FULL;
		end else if (xf < jetcm_pkg::Q_2F) begin
			red_d   = '0;
			green_d = jetcm_pkg::CHAN_FULL;
			blue_d  = jetcm_pkg::chan_t'(jetcm_pkg::Q_2F - xc);
		end else if (xf < jetcm_pkg::Q_3F) begin
			red_d   = jetcm_pkg::chan_t'(xf - jetcm_pkg::Q_2F);
			green_d = jetcm_pkg::CHAN_FULL;
			blue_d  = '0;
		end else begin
			red_d   = jetcm_pkg::CHAN_FULL;
			green_d = jetcm_pkg::chan_t'(jetcm_pkg::Q_4F - xc);
			blue_d  = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= div_valid_s[NS-1];
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			red_q   <= red_d;
			green_q <= green_d;
			blue_q  <= blue_d;
		end
	end

	// pixel word out
	assign pixels.valid = out_valid_q;
	assign pixels.red   = red_q;
	assign pixels.green = green_q;
	assign pixels.blue  = blue_q;

endmodule

// File: tb/sv/jetcm_pixel_checker.sv
`timescale 1ns / 1ps
// jetcm_pixel_checker: watches the sample and pixel channels and the register port,
// predicts each pixel word from the jet ramp and compares; depends on jetcm_pkg and jetcm_if
module jetcm_pixel_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_wr_en,
	input  logic               cfg_index,
	input  jetcm_pkg::sample_t cfg_data,
	jetcm_sample_if            samples,
	jetcm_pixel_if             pixels,
	output int unsigned        fails,
	output int unsigned        pending
);
	import jetcm_pkg::*;

	typedef struct {
		sample_t sample;
		chan_t   red;
		chan_t   green;
		chan_t   blue;
	} pixel_word_t;

	sample_t     range_lo;
	sample_t     range_hi;
	pixel_word_t pixel_q[$];

	// jet ramp: clamp, scale to 0..4*full, then pick the quarter
	function automatic pixel_word_t jet_pixel(sample_t s, sample_t lo, sample_t hi);
		longint unsigned v, d, dv, num, xf, xc, full;
		pixel_word_t     p;
		full     = CHAN_FULL_INT;
		p.sample = s;
		if (hi <= lo) begin
			// empty or inverted range gives pure red
			p.red   = chan_t'(full);
			p.green = '0;
			p.blue  = '0;
		end else begin
			v = s;
			if (v < lo)
				v = lo;
			if (v > hi)
				v = hi;
			dv  = hi - lo;
			d   = v - lo;
			num = 4 * full * d;
			xf  = num / dv;
			xc  = xf + ((num % dv) != 0);
			if (xf < full) begin
				p.red   = '0;
				p.green = chan_t'(xf);
				p.blue  = chan_t'(full);
			end else if (xf < 2 * full) begin
				p.red   = '0;
				p.green = chan_t'(full);
				p.blue  = chan_t'(2 * full - xc);
			end else if (xf < 3 * full) begin
				p.red   = chan_t'(xf - 2 * full);
				p.green = chan_t'(full);
				p.blue  = '0;
			end else begin
				p.red   = chan_t'(full);
				p.green = chan_t'(4 * full - xc);
				p.blue  = '0;
			end
		end
		return p;
	endfunction

	// register copy, prediction on each accepted sample word, compare on each pixel word
	always @(posedge clk or negedge arst_n) begin
		pixel_word_t want;
		if (!arst_n) begin
			range_lo = LOWER_RESET;
			range_hi = UPPER_RESET;
			pixel_q.delete();
			fails    = 0;
			pending  = 0;
		end else begin
			if (cfg_wr_en) begin
				if (cfg_reg_t'(cfg_index) == REG_RANGE_LOWER)
					range_lo = cfg_data;
				else if (cfg_reg_t'(cfg_index) == REG_RANGE_UPPER)
					range_hi = cfg_data;
			end
			if (pixels.valid && pixels.ready) begin
				if (pixel_q.size() == 0) begin
					fails++;
					if (fails <= 10)
						$display("unexpected pixel word r=%0d g=%0d b=%0d",
							pixels.red, pixels.green, pixels.blue);
				end else begin
					want = pixel_q.pop_front();
					if (pixels.red !== want.red || pixels.green !== want.green ||
						pixels.blue !== want.blue) begin
						fails++;
						if (fails <= 10)
							$display("pixel mismatch sample=%0d: want r=%0d g=%0d b=%0d, got r=%0d g=%0d b=%0d",
								want.sample, want.red, want.green, want.blue,
								pixels.red, pixels.green, pixels.blue);
					end
				end
			end
			if (samples.valid && samples.ready)
				pixel_q.push_back(jet_pixel(samples.sample, range_lo, range_hi));
			pending = pixel_q.size();
		end
	end

endmodule

// File: tb/sv/tb_value_to_jet_colormap_top.sv
`timescale 1ns / 1ps
// tb_value_to_jet_colormap_top: drives sample words and register writes into the jet colour map,
// paces the pixel side and gives the verdict; depends on jetcm_pkg, jetcm_if and jetcm_pixel_checker
module tb_value_to_jet_colormap_top;
	import jetcm_pkg::*;

	localparam int LATENCY      = DIV_STAGES + 3;
	localparam int CYCLE_LIMIT  = 500000;
	localparam int HOLD_CYCLES  = 250;
	localparam int RAND_PHASES  = 13;
	localparam int PHASE_WORDS  = 150;

	logic        clk;
	logic        arst_n;
	logic        cfg_wr_en;
	cfg_reg_t    cfg_index;
	sample_t     cfg_data;
	int unsigned fails;
	int unsigned pending;
	int unsigned cycles;
	int unsigned send_mode;
	int unsigned words_taken;

	jetcm_sample_if samples_ch ();
	jetcm_pixel_if  pixels_ch ();

	value_to_jet_colormap_top u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.samples   (samples_ch),
		.pixels    (pixels_ch)
	);

	jetcm_pixel_checker u_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.samples   (samples_ch),
		.pixels    (pixels_ch),
		.fails     (fails),
		.pending   (pending)
	);

	// clock
	initial clk = 1'b0;
	always #5 clk = ~clk;

	// run limit
	initial cycles = 0;
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("value_to_jet_colormap_top test failed");
			$finish;
		end
	end

	// gap before the next sample word, shaped by the current sender mode
	function automatic int unsigned send_gap();
		case (send_mode)
			0: return $urandom_range(0, 15);
			1: return 0;
			default: return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : 0;
		endcase
	endfunction

	// offer one sample word, called at a falling edge and returning at one
	task automatic send_word(sample_t s);
		int unsigned gap;
		gap = send_gap();
		if (gap > 0) begin
			samples_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		samples_ch.valid  <= 1'b1;
		samples_ch.sample <= s;
		@(posedge clk);
		while (!samples_ch.ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	// wait for the pipeline to drain, then write both range registers
	task automatic set_range(sample_t lo, sample_t hi);
		samples_ch.valid <= 1'b0;
		@(negedge clk);
		while (pending != 0)
			@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= REG_RANGE_LOWER;
		cfg_data  <= lo;
		@(negedge clk);
		cfg_index <= REG_RANGE_UPPER;
		cfg_data  <= hi;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		@(negedge clk);
	endtask

	// random range: full span, fully random, narrow, wide, empty, inverted, or anchored at an extreme
	task automatic rand_range(output sample_t lo, output sample_t hi);
		case ($urandom_range(0, 7))
			0: begin lo = '0; hi = '1; end
			1: begin lo = sample_t'($urandom); hi = sample_t'($urandom); end
			2: begin
				lo = sample_t'($urandom_range(0, 65000));
				hi = lo + sample_t'($urandom_range(1, 8));
			end
			3: begin lo = sample_t'($urandom); hi = lo; end
			4: begin lo = '0; hi = sample_t'($urandom_range(1, 65535)); end
			5: begin lo = sample_t'($urandom_range(0, 65534)); hi = '1; end
			6: begin
				lo = sample_t'($urandom_range(0, 30000));
				hi = lo + sample_t'($urandom_range(1000, 35000));
			end
			default: begin
				lo = sample_t'($urandom_range(1, 65535));
				hi = sample_t'($urandom_range(0, int'(lo) - 1));
			end
		endcase
	endtask

	// mostly in range, some near the bounds, some at the extremes, some anywhere
	function automatic sample_t rand_sample(sample_t lo, sample_t hi);
		int unsigned pick;
		pick = $urandom_range(0, 99);
		if (pick < 65 && hi > lo)
			return sample_t'($urandom_range(int'(lo), int'(hi)));
		else if (pick < 80)
			return lo + sample_t'($urandom_range(0, 4)) - sample_t'(2);
		else if (pick < 88)
			return hi + sample_t'($urandom_range(0, 4)) - sample_t'(2);
		else if (pick < 94)
			return ($urandom_range(0, 1) != 0) ? '1 : '0;
		else
			return sample_t'($urandom);
	endfunction

	// pixel side: random stalls per word, plus two long hold-offs while samples keep coming
	initial begin
		int unsigned gap;
		int unsigned stall_mode;
		pixels_ch.ready = 1'b0;
		words_taken     = 0;
		stall_mode      = 0;
		wait (arst_n);
		@(negedge clk);
		forever begin
			if (words_taken % 64 == 0)
				stall_mode = $urandom_range(0, 2);
			if (words_taken == 300 || words_taken == 1100) begin
				pixels_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end
			case (stall_mode)
				0: gap = $urandom_range(0, 15);
				1: gap = 0;
				default: gap = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : 0;
			endcase
			if (gap > 0) begin
				pixels_ch.ready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			pixels_ch.ready <= 1'b1;
			@(posedge clk);
			while (!pixels_ch.valid)
				@(posedge clk);
			words_taken++;
			@(negedge clk);
		end
	end

	// reset, directed cases, random phases, drain and verdict
	initial begin
		sample_t dir_q[$];
		sample_t lo;
		sample_t hi;
		arst_n            = 1'b0;
		cfg_wr_en         = 1'b0;
		cfg_index         = REG_RANGE_LOWER;
		cfg_data          = '0;
		samples_ch.valid  = 1'b0;
		samples_ch.sample = '0;
		send_mode         = 0;
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset range: extremes and both sides of each quarter boundary
		dir_q = '{16'd0, 16'd1, 16'd16383, 16'd16384, 16'd32767, 16'd32768,
			16'd49151, 16'd49152, 16'd65534, 16'd65535};
		foreach (dir_q[i])
			send_word(dir_q[i]);

		// empty range gives pure red
		set_range(16'd0, 16'd0);
		send_word(16'd0);
		send_word(16'd65535);

		// inverted range at the extremes
		set_range(16'd65535, 16'd0);
		send_word(16'd75);

		// span of four hits every boundary exactly, plus clamping on both sides
		set_range(16'd200, 16'd204);
		dir_q = '{16'd199, 16'd200, 16'd201, 16'd202, 16'd203, 16'd204, 16'd205};
		foreach (dir_q[i])
			send_word(dir_q[i]);

		// span of three divides 4*full exactly, so floor and ceiling agree
		set_range(16'd1000, 16'd1003);
		send_word(16'd1001);
		send_word(16'd1002);

		// narrowest span at the top end
		set_range(16'd65534, 16'd65535);
		send_word(16'd65534);
		send_word(16'd65535);

		// random phases, each with its own range and sender pacing
		for (int p = 0; p < RAND_PHASES; p++) begin
			rand_range(lo, hi);
			set_range(lo, hi);
			send_mode = $urandom_range(0, 2);
			for (int n = 0; n < PHASE_WORDS; n++)
				send_word(rand_sample(lo, hi));
		end

		// drain, then give stray words time to show up
		samples_ch.valid <= 1'b0;
		@(negedge clk);
		while (pending != 0)
			@(negedge clk);
		repeat (LATENCY + 4) @(negedge clk);

		if (fails == 0 && pending == 0)
			$display("value_to_jet_colormap_top test passed");
		else
			$display("value_to_jet_colormap_top test failed");
		$finish;
	end

endmodule

// File: value_to_jet_colormap_top.f
rtl/jetcm_pkg.sv
rtl/jetcm_if.sv
rtl/value_to_jet_colormap_top.sv
tb/sv/jetcm_pixel_checker.sv
tb/sv/tb_value_to_jet_colormap_top.sv
